[hw/rtl/row_edge_detector_defines.svh]
// Assertion macros used by row_edge_detector.sv to check its own logic.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef ROW_EDGE_DETECTOR_DEFINES_SVH
`define ROW_EDGE_DETECTOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RED_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RED_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/red_pkg.sv]
`default_nettype none

package red_pkg;

  localparam int DEF_MAX_ROW_WIDTH = 256;
  localparam int DEF_HISTORY_DEPTH = 16;

  localparam int PIX_W  = 8;
  localparam int POS_W  = 8;
  localparam int DIST_W = 4;
  localparam int THR_W  = 8;
  localparam int KIND_W = 2;
  localparam int CIDX_W = 2;

  localparam logic [DIST_W-1:0] DEF_EDGE_DISTANCE = 4'd4;
  localparam logic [THR_W-1:0]  DEF_STRONG        = 8'd20;
  localparam logic [THR_W-1:0]  DEF_WEAK          = 8'(20 * 3 / 5);

  typedef enum logic [KIND_W-1:0] {
    KIND_ROW  = 2'd0,
    KIND_RISE = 2'd1,
    KIND_FALL = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_FELL = 2'd1,
    MODE_ROSE = 2'd2
  } mode_e;

  typedef enum logic [CIDX_W-1:0] {
    REG_EDGE_DISTANCE    = 2'd0,
    REG_STRONG_THRESHOLD = 2'd1,
    REG_WEAK_THRESHOLD   = 2'd2
  } reg_idx_e;

  // What the detector decides for the pixel held in the input register.
  typedef struct packed {
    logic             store;
    logic             hit;
    kind_e            kind;
    logic [POS_W-1:0] position;
  } det_res_t;

endpackage

`default_nettype wire

[hw/rtl/red_history.sv]
`default_nettype none

module red_history #(
  parameter int HISTORY_DEPTH = red_pkg::DEF_HISTORY_DEPTH
) (
  input  wire logic                      clk_i,
  input  wire logic                      shift_i,
  input  wire logic [red_pkg::PIX_W-1:0]  pixel_i,
  input  wire logic [red_pkg::DIST_W-1:0] distance_i,
  output      logic [red_pkg::DIST_W-1:0] dist_o,
  output      logic [red_pkg::PIX_W-1:0]  sample_o
);
  import red_pkg::*;

  // The distance cannot exceed the history, nor what the register can hold.
  localparam int DMAX = (1 << DIST_W) - 1;
  localparam int NTAP = (HISTORY_DEPTH - 1 > DMAX) ? DMAX : HISTORY_DEPTH - 1;
  localparam logic [DIST_W-1:0] DLIM = DIST_W'(NTAP);

  // Tap k holds the pixel stored k + 1 pixels before the current one.
  logic [PIX_W-1:0] tap_q [NTAP];

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      tap_q[0] <= pixel_i;
      for (int k = 1; k < NTAP; k++) begin
        tap_q[k] <= tap_q[k-1];
      end
    end
  end

  assign dist_o = (distance_i > DLIM) ? DLIM : distance_i;

  // A distance of zero compares the pixel with itself.
  always_comb begin
    sample_o = pixel_i;
    for (int k = 0; k < NTAP; k++) begin
      if (dist_o == DIST_W'(k + 1)) begin
        sample_o = tap_q[k];
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/red_detector.sv]
`default_nettype none

module red_detector #(
  parameter int MAX_ROW_WIDTH = red_pkg::DEF_MAX_ROW_WIDTH
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      advance_i,
  input  wire logic [red_pkg::PIX_W-1:0]  pixel_i,
  input  wire logic                      start_i,
  input  wire logic [red_pkg::PIX_W-1:0]  sample_i,
  input  wire logic [red_pkg::DIST_W-1:0] dist_i,
  input  wire logic [red_pkg::THR_W-1:0]  strong_i,
  input  wire logic [red_pkg::THR_W-1:0]  weak_i,
  output      red_pkg::det_res_t          res_o
);
  import red_pkg::*;

  localparam int CW = $clog2(MAX_ROW_WIDTH + 1);
  localparam int SW = (CW > POS_W) ? CW : POS_W;

  logic [CW-1:0]  col_q, col_d;
  mode_e          mode_q, mode_d;
  logic [1:0]     skip_q, skip_d;

  logic signed [THR_W+1:0] diff, strong_s, weak_s;
  logic [SW-1:0]           pos_full;
  logic                    edge_hit;
  kind_e                   edge_kind;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      mode_q <= MODE_IDLE;
      skip_q <= '0;
    end else if (advance_i) begin
      col_q  <= col_d;
      mode_q <= mode_d;
      skip_q <= skip_d;
    end
  end

  assign diff     = signed'({2'b00, pixel_i}) - signed'({2'b00, sample_i});
  assign strong_s = signed'({2'b00, strong_i});
  assign weak_s   = signed'({2'b00, weak_i});
  assign pos_full = SW'(col_q) - SW'(dist_i);

  always_comb begin
    col_d     = col_q;
    mode_d    = mode_q;
    skip_d    = skip_q;
    edge_hit  = 1'b0;
    edge_kind = KIND_RISE;
    res_o     = '{store: 1'b0, hit: 1'b0, kind: KIND_ROW, position: '0};

    if (start_i) begin
      res_o  = '{store: 1'b1, hit: 1'b1, kind: KIND_ROW, position: '0};
      col_d  = CW'(1);
      mode_d = MODE_IDLE;
      skip_d = '0;
    end else if (col_q < CW'(MAX_ROW_WIDTH)) begin
      res_o.store = 1'b1;
      col_d       = col_q + CW'(1);
      if (col_q >= CW'(dist_i)) begin
        if (skip_q != 2'd0) begin
          skip_d = skip_q - 2'd1;
        end else begin
          unique case (mode_q)
            MODE_FELL: begin
              if (diff > -weak_s) begin
                mode_d = MODE_IDLE;
              end else if (diff >= strong_s) begin
                edge_hit  = 1'b1;
                edge_kind = KIND_RISE;
              end
            end
            MODE_ROSE: begin
              if (diff < weak_s) begin
                mode_d = MODE_IDLE;
              end else if (diff <= -strong_s) begin
                edge_hit  = 1'b1;
                edge_kind = KIND_FALL;
              end
            end
            default: begin
              mode_d = MODE_IDLE;
              if (diff <= -strong_s) begin
                edge_hit  = 1'b1;
                edge_kind = KIND_FALL;
              end else if (diff >= strong_s) begin
                edge_hit  = 1'b1;
                edge_kind = KIND_RISE;
              end
            end
          endcase
          if (edge_hit) begin
            mode_d         = (edge_kind == KIND_FALL) ? MODE_FELL : MODE_ROSE;
            skip_d         = 2'd2;
            res_o.hit      = 1'b1;
            res_o.kind     = edge_kind;
            res_o.position = pos_full[POS_W-1:0];
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/row_edge_detector.sv]
// Channel   Direction  Handshake            Request contents
// input     in         in_valid_i/in_stall_o    pixel_i, row_start_i
// result    out        out_valid_o/out_stall_i  event_kind_o, position_o
// config    in         cfg_valid_i/cfg_ready_o  cfg_index_i, cfg_data_i
//
// One pixel request is taken every cycle while in_stall_o is low; its result,
// if any, passes through the input register and the result register before it
// is on offer on the result channel.
// Reset clears the control state and loads the default configuration; the
// pixel history needs no clearing, as every tap is written before it is read.
// in_stall_o rises only when the pending pixel yields a result while the
// result register is full and stalled; pixels without a result never wait.
`default_nettype none

module row_edge_detector #(
  parameter int MAX_ROW_WIDTH = red_pkg::DEF_MAX_ROW_WIDTH,
  parameter int HISTORY_DEPTH = red_pkg::DEF_HISTORY_DEPTH
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,

  input  wire logic                       in_valid_i,
  output      logic                       in_stall_o,
  input  wire logic [red_pkg::PIX_W-1:0]   pixel_i,
  input  wire logic                       row_start_i,

  output      logic                       out_valid_o,
  input  wire logic                       out_stall_i,
  output      logic [red_pkg::KIND_W-1:0]  event_kind_o,
  output      logic [red_pkg::POS_W-1:0]   position_o,

  input  wire logic                       cfg_valid_i,
  output      logic                       cfg_ready_o,
  input  wire logic [red_pkg::CIDX_W-1:0]  cfg_index_i,
  input  wire logic [red_pkg::THR_W-1:0]   cfg_data_i
);
  import red_pkg::*;
`include "row_edge_detector_defines.svh"

  // Configuration registers. Writes are always taken; an index beyond the
  // register list is simply ignored.
  logic [DIST_W-1:0] dist_cfg_q;
  logic [THR_W-1:0]  strong_q;
  logic [THR_W-1:0]  weak_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dist_cfg_q <= DEF_EDGE_DISTANCE;
      strong_q   <= DEF_STRONG;
      weak_q     <= DEF_WEAK;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_EDGE_DISTANCE:    dist_cfg_q <= cfg_data_i[DIST_W-1:0];
        REG_STRONG_THRESHOLD: strong_q   <= cfg_data_i;
        REG_WEAK_THRESHOLD:   weak_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input register. It holds one pixel request until the detector has dealt
  // with it, which happens in the very next cycle unless that pixel produces a
  // result and the result register cannot take it.
  logic             in_valid_q;
  logic [PIX_W-1:0] pix_q;
  logic             start_q;
  logic             in_take;
  logic             advance;
  logic             out_free;

  det_res_t          res;
  logic [DIST_W-1:0] dist_eff;
  logic [PIX_W-1:0]  sample;

  assign out_free   = !out_valid_o || !out_stall_i;
  assign advance    = in_valid_q && (!res.hit || out_free);
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      pix_q   <= pixel_i;
      start_q <= row_start_i;
    end
  end

  // Shift line of recent pixels in the current row, with the tap chosen by the
  // effective edge distance.
  red_history #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_history (
    .clk_i      (clk_i),
    .shift_i    (advance && res.store),
    .pixel_i    (pix_q),
    .distance_i (dist_cfg_q),
    .dist_o     (dist_eff),
    .sample_o   (sample)
  );

  // Column counter, detector mode and skip counter, with the edge decision.
  red_detector #(
    .MAX_ROW_WIDTH (MAX_ROW_WIDTH)
  ) u_detector (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .pixel_i   (pix_q),
    .start_i   (start_q),
    .sample_i  (sample),
    .dist_i    (dist_eff),
    .strong_i  (strong_q),
    .weak_i    (weak_q),
    .res_o     (res)
  );

  // Result register. A new result may replace the old one in the cycle in
  // which the old one is taken.
  logic             out_valid_q;
  kind_e            out_kind_q;
  logic [POS_W-1:0] out_pos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && res.hit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res.hit) begin
      out_kind_q <= res.kind;
      out_pos_q  <= res.position;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign event_kind_o = out_kind_q;
  assign position_o   = out_pos_q;

  // A result handed to the result register must be on offer in the next cycle.
  `RED_ASSERT_NEXT(a_result_loaded, advance && res.hit, out_valid_o, "result lost")

  // The input side waits only for a result blocked behind a stalled one.
  `RED_ASSERT_IMP(a_stall_cause, in_stall_o,
                  in_valid_q && res.hit && out_valid_o && out_stall_i, "needless stall")

  // A row start always yields its marker and nothing else.
  `RED_ASSERT_IMP(a_row_marker, advance && start_q,
                  res.hit && (res.kind == KIND_ROW) && (res.position == '0), "row marker")

endmodule

`default_nettype wire

[dv/tb.sv]
`timescale 1ns / 1ps

// Testbench for row_edge_detector.
//
// Pixel requests go in through the valid/stall input channel, edge events come
// back through the valid/stall result channel, and the three threshold and
// distance registers are loaded through the configuration write channel.
//
// Every accepted pixel request is run through a local copy of the detector
// (predict_edge), which keeps its own pixel history, column count, detector
// mode and skip count. Any event it produces is queued in pending_events. The
// result monitor compares every accepted result request, field by field, with
// the oldest queued event.
//
// The run has a short directed part, walked from a table, and then a series of
// random phases. Each phase loads a new configuration while the block is idle,
// the extremes first, and then sends rows built from flat levels with sudden
// jumps, so that the detector passes through all of its modes. Plain random rows,
// rows without a start flag and stray start flags in mid-row make up the rest.
module tb;
  import red_pkg::*;

  localparam int PHASES       = 11;
  localparam int PHASE_ITEMS  = 100;
  localparam int SETTLE_CYC   = 8;
  localparam int DIR_N        = 26;

  // One expected result request.
  typedef struct packed {
    kind_e            kind;
    logic [POS_W-1:0] pos;
  } edge_event_t;

  // One row of the directed table. Where typed is set, the expected event is
  // given in the row itself; otherwise the predictor decides.
  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             start;
    logic             typed;
    kind_e            kind;
    logic [POS_W-1:0] pos;
  } dir_row_t;

  // The directed rows run on the reset configuration: distance 4, strong 20 and
  // weak 12. The first pixels come without a row start, so they must count as
  // a row from column zero.
  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    '{8'd0,   1'b0, 1'b0, KIND_ROW,  8'd0},
    '{8'd0,   1'b0, 1'b0, KIND_ROW,  8'd0},
    '{8'd0,   1'b0, 1'b0, KIND_ROW,  8'd0},
    '{8'd0,   1'b0, 1'b0, KIND_ROW,  8'd0},
    '{8'd255, 1'b0, 1'b1, KIND_RISE, 8'd0},
    '{8'd255, 1'b0, 1'b0, KIND_ROW,  8'd0},
    '{8'd255, 1'b0, 1'b0, KIND_ROW,  8'd0},
    '{8'd255, 1'b0, 1'b0, KIND_ROW,  8'd0},
    '{8'd0,   1'b0, 1'b0, KIND_ROW,  8'd0},
    '{8'd0,   1'b0, 1'b0, KIND_ROW,  8'd0},
    '{8'd0,   1'b0, 1'b0, KIND_ROW,  8'd0},
    '{8'd0,   1'b0, 1'b0, KIND_ROW,  8'd0},
    '{8'd0,   1'b0, 1'b0, KIND_ROW,  8'd0},
    '{8'd255, 1'b1, 1'b1, KIND_ROW,  8'd0},
    '{8'd200, 1'b0, 1'b0, KIND_ROW,  8'd0},
    '{8'd200, 1'b0, 1'b0, KIND_ROW,  8'd0},
    '{8'd200, 1'b0, 1'b0, KIND_ROW,  8'd0},
    '{8'd200, 1'b0, 1'b0, KIND_ROW,  8'd0},
    '{8'd0,   1'b1, 1'b1, KIND_ROW,  8'd0},
    '{8'd10,  1'b0, 1'b0, KIND_ROW,  8'd0},
    '{8'd10,  1'b0, 1'b0, KIND_ROW,  8'd0},
    '{8'd10,  1'b0, 1'b0, KIND_ROW,  8'd0},
    '{8'd10,  1'b0, 1'b0, KIND_ROW,  8'd0},
    '{8'd10,  1'b0, 1'b0, KIND_ROW,  8'd0},
    '{8'd40,  1'b0, 1'b0, KIND_ROW,  8'd0},
    '{8'd128, 1'b1, 1'b1, KIND_ROW,  8'd0}
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  logic [PIX_W-1:0]    pixel_i     = '0;
  logic                row_start_i = 1'b0;

  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [KIND_W-1:0]   event_kind_o;
  logic [POS_W-1:0]    position_o;

  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CIDX_W-1:0]   cfg_index_i = '0;
  logic [THR_W-1:0]    cfg_data_i  = '0;

  // Configuration and state of the local detector copy.
  logic [DIST_W-1:0]   dist_cfg   = DEF_EDGE_DISTANCE;
  logic [THR_W-1:0]    strong_cfg = DEF_STRONG;
  logic [THR_W-1:0]    weak_cfg   = DEF_WEAK;
  logic [PIX_W-1:0]    pix_hist [DEF_HISTORY_DEPTH];
  int                  col_cnt    = 0;
  mode_e               det_mode   = MODE_IDLE;
  int                  skip_cnt   = 0;

  edge_event_t         pending_events [$];
  int                  fail_cnt   = 0;
  int                  report_cnt = 0;

  // While quiet is set neither side idles, so that stretches at full rate
  // occur as well.
  bit                  quiet      = 1'b0;
  int                  quiet_left = 0;
  int                  stall_left = 0;

  row_edge_detector u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .pixel_i      (pixel_i),
    .row_start_i  (row_start_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .event_kind_o (event_kind_o),
    .position_o   (position_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Local copy of the detector: takes one accepted pixel request and says
  // whether it causes an event, and which.
  task automatic predict_edge(input logic [PIX_W-1:0] pix, input logic start,
                              output bit hit, output kind_e kind,
                              output logic [POS_W-1:0] pos);
    int dist_v;
    int diff;
    int col;
    int strong_v;
    int weak_v;
    hit      = 1'b0;
    kind     = KIND_ROW;
    pos      = '0;
    dist_v   = int'(dist_cfg);
    strong_v = int'(strong_cfg);
    weak_v   = int'(weak_cfg);
    if (dist_v > DEF_HISTORY_DEPTH - 1) begin
      dist_v = DEF_HISTORY_DEPTH - 1;
    end

    // A row start clears the detector and only ever yields the marker.
    if (start) begin
      det_mode    = MODE_IDLE;
      skip_cnt    = 0;
      pix_hist[0] = pix;
      col_cnt     = 1;
      hit         = 1'b1;
      return;
    end

    // Pixels past the maximum row width are dropped.
    if (col_cnt >= DEF_MAX_ROW_WIDTH) begin
      return;
    end
    col = col_cnt;
    pix_hist[col % DEF_HISTORY_DEPTH] = pix;
    col_cnt = col + 1;

    // Nothing is evaluated until the far sample of the first position exists.
    if (col < dist_v) begin
      return;
    end
    diff = int'(pix) - int'(pix_hist[(col - dist_v) % DEF_HISTORY_DEPTH]);

    if (skip_cnt != 0) begin
      skip_cnt--;
      return;
    end
    case (det_mode)
      MODE_FELL: begin
        if (diff > -weak_v) begin
          det_mode = MODE_IDLE;
        end else if (diff >= strong_v) begin
          hit  = 1'b1;
          kind = KIND_RISE;
        end
      end
      MODE_ROSE: begin
        if (diff < weak_v) begin
          det_mode = MODE_IDLE;
        end else if (diff <= -strong_v) begin
          hit  = 1'b1;
          kind = KIND_FALL;
        end
      end
      default: begin
        det_mode = MODE_IDLE;
        if (diff <= -strong_v) begin
          hit  = 1'b1;
          kind = KIND_FALL;
        end else if (diff >= strong_v) begin
          hit  = 1'b1;
          kind = KIND_RISE;
        end
      end
    endcase
    if (hit) begin
      det_mode = (kind == KIND_FALL) ? MODE_FELL : MODE_ROSE;
      skip_cnt = 2;
      pos      = POS_W'(col - dist_v);
    end
  endtask

  // Sends one pixel request after a random gap and queues what it causes.
  // Valid is only lowered when a gap follows, so back-to-back requests keep
  // it high without a second assignment in the same step.
  task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic start,
                            input logic typed, input kind_e typed_kind,
                            input logic [POS_W-1:0] typed_pos);
    int gap;
    bit hit;
    kind_e kind;
    logic [POS_W-1:0] pos;
    gap = quiet ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    pixel_i     <= pix;
    row_start_i <= start;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);

    predict_edge(pix, start, hit, kind, pos);
    if (typed) begin
      pending_events.push_back(edge_event_t'{typed_kind, typed_pos});
    end else if (hit) begin
      pending_events.push_back(edge_event_t'{kind, pos});
    end

    if (quiet_left == 0) begin
      quiet      = ($urandom_range(0, 3) == 0);
      quiet_left = $urandom_range(20, 120);
    end else begin
      quiet_left--;
    end
  endtask

  // Lowers valid after the last request and waits until the block is idle:
  // every queued event has come back, and a settling wait covers a pixel that
  // is still in flight without a result.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  // Loads all three registers, one write request each, back to back.
  task automatic write_config(input logic [DIST_W-1:0] dist_v,
                              input logic [THR_W-1:0] strong_v,
                              input logic [THR_W-1:0] weak_v);
    reg_idx_e idx;
    for (int i = 0; i < 3; i++) begin
      idx = reg_idx_e'(i);
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx;
      case (idx)
        REG_EDGE_DISTANCE:    cfg_data_i <= THR_W'(dist_v);
        REG_STRONG_THRESHOLD: cfg_data_i <= strong_v;
        default:              cfg_data_i <= weak_v;
      endcase
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      case (idx)
        REG_EDGE_DISTANCE:    dist_cfg   = dist_v;
        REG_STRONG_THRESHOLD: strong_cfg = strong_v;
        default:              weak_cfg   = weak_v;
      endcase
    end
    cfg_valid_i <= 1'b0;
  endtask

  // Sends one random row. Most rows hold flat levels with sudden jumps, which
  // walk the detector through rising, falling and back to idle; some are pure
  // noise. Now and then the start flag is left off, so that the row runs on
  // from the previous one, or a stray start appears in mid-row.
  task automatic send_row(input int len, inout int sent);
    int style;
    int level;
    int lv;
    logic start;
    style = $urandom_range(0, 3);
    level = $urandom_range(0, 255);
    for (int i = 0; i < len; i++) begin
      if (style == 0) begin
        lv = $urandom_range(0, 255);
      end else begin
        if ($urandom_range(0, 7) == 0) begin
          case ($urandom_range(0, 3))
            0:       level = 0;
            1:       level = 255;
            default: level = $urandom_range(0, 255);
          endcase
        end
        lv = level + $urandom_range(0, 6) - 3;
        if (lv < 0) lv = 0;
        if (lv > 255) lv = 255;
      end
      if (i == 0) begin
        start = ($urandom_range(0, 15) != 0);
      end else begin
        start = ($urandom_range(0, 99) == 0);
      end
      send_pixel(PIX_W'(lv), start, 1'b0, KIND_ROW, '0);
      sent++;
    end
  endtask

  // Result side: checks every accepted result request against the oldest
  // queued event and then, unless quiet is set, stalls for a random number of cycles.
  always @(posedge clk_i) begin : result_monitor
    edge_event_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_events.size() == 0) begin
          fail_cnt++;
          if (report_cnt < 10) begin
            report_cnt++;
            $display("%0t: unexpected result kind %0d position %0d", $time,
                     event_kind_o, position_o);
          end
        end else begin
          want = pending_events.pop_front();
          if (event_kind_o !== want.kind || position_o !== want.pos) begin
            fail_cnt++;
            if (report_cnt < 10) begin
              report_cnt++;
              $display("%0t: mismatch kind exp %0d got %0d, position exp %0d got %0d",
                       $time, want.kind, event_kind_o, want.pos, position_o);
            end
          end
        end
        stall_left = quiet ? 0 : $urandom_range(0, 16);
      end else if (stall_left != 0) begin
        stall_left--;
      end
      out_stall_i <= (stall_left != 0);
    end
  end

  // Main sequence: reset, directed table, random phases, then the verdict.
  initial begin : main_seq
    int sent;
    int len;
    logic [DIST_W-1:0] dist_v;
    logic [THR_W-1:0]  strong_v;
    logic [THR_W-1:0]  weak_v;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DIR_N; i++) begin
      send_pixel(DIR_ROWS[i].pix, DIR_ROWS[i].start, DIR_ROWS[i].typed,
                 DIR_ROWS[i].kind, DIR_ROWS[i].pos);
    end
    wait_idle();

    // The first phases take the register extremes, including a distance of zero,
    // where every difference is zero, then the reset defaults; the rest are random.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin dist_v = 4'd0;  strong_v = 8'd0;   weak_v = 8'd0;   end
        1: begin dist_v = 4'd15; strong_v = 8'd255; weak_v = 8'd255; end
        2: begin dist_v = 4'd1;  strong_v = 8'd255; weak_v = 8'd0;   end
        3: begin dist_v = 4'd15; strong_v = 8'd0;   weak_v = 8'd255; end
        4: begin
          dist_v = DEF_EDGE_DISTANCE; strong_v = DEF_STRONG; weak_v = DEF_WEAK;
        end
        default: begin
          dist_v   = DIST_W'($urandom_range(0, 15));
          strong_v = THR_W'($urandom_range(1, 96));
          weak_v   = THR_W'($urandom_range(0, int'(strong_v)));
        end
      endcase
      write_config(dist_v, strong_v, weak_v);

      // Mostly short rows; now and then one longer than the maximum width,
      // so that the pixels past the end are dropped.
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(0, 24) == 0) begin
          len = $urandom_range(DEF_MAX_ROW_WIDTH + 1, DEF_MAX_ROW_WIDTH + 24);
        end else begin
          len = $urandom_range(1, 48);
        end
        send_row(len, sent);
      end
      wait_idle();
    end

    if (fail_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Guard against a hang; well beyond the slowest correct run.
  initial begin : watchdog
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
